FILE: design/gpcr_pkg.sv
package gpcr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int COEF_W    = 31;
    localparam int KIND_W    = 2;
    localparam int IDX_W     = 2;
    localparam int IN_W      = 9 * DATA_W;
    localparam int OUT_W     = 7 * DATA_W;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + 1;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PEN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVR  = 2'd2;

    localparam logic [IDX_W-1:0] REG_RESTITUTION = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRICTION    = 2'd1;
    localparam logic [IDX_W-1:0] REG_SPRING      = 2'd2;
    localparam logic [IDX_W-1:0] REG_DAMP        = 2'd3;

    // band limit 0.05 and penalty rest offset 0.01, rounded to nearest
    localparam logic signed [DATA_W-1:0] BAND =
        DATA_W'(((5 << FRAC_BITS) + 50) / 100);
    localparam logic signed [DATA_W-1:0] OFFS =
        DATA_W'(((1 << FRAC_BITS) + 50) / 100);

    localparam logic [COEF_W-1:0] SPRING_RST = COEF_W'(1000 << FRAC_BITS);
    localparam logic [COEF_W-1:0] DAMP_RST   = COEF_W'(50 << FRAC_BITS);

    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [COEF_W-1:0] restitution;
        logic [COEF_W-1:0] friction;
        logic [COEF_W-1:0] spring;
        logic [COEF_W-1:0] damp;
    } coef_t;

    // one classified vertex waiting for the arithmetic back end
    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic                      last;
        logic signed [DATA_W-1:0]  op_a;
        logic signed [DATA_W-1:0]  op_b;
        logic signed [DATA_W-1:0]  op_c;
        logic signed [DATA_W-1:0]  disp_x;
        logic signed [DATA_W-1:0]  disp_y;
        logic signed [DATA_W-1:0]  disp_z;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1])
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // shift a product magnitude down, round half away from zero, saturate
    function automatic logic [DATA_W-1:0] rescale(input logic neg, input logic [SUM_W-1:0] mag);
        logic [SUM_W-1:0]  r;
        logic [DATA_W-1:0] res;
        r = (mag + HALF) >> FRAC_BITS;
        if (neg)
        begin
            if (r >= (SUM_W'(1) << (DATA_W - 1)))
                res = {1'b1, {(DATA_W-1){1'b0}}};
            else
                res = DATA_W'(0) - r[DATA_W-1:0];
        end
        else
        begin
            if (r >= (SUM_W'(1) << (DATA_W - 1)))
                res = {1'b0, {(DATA_W-1){1'b1}}};
            else
                res = r[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: design/gpcr_front.sv
module gpcr_front (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [gpcr_pkg::IN_W-1:0]   s_tdata,
    input  logic                        s_tlast,
    input  gpcr_pkg::q_stat_t           q_stat,
    output logic                        push,
    output gpcr_pkg::entry_t            push_data
);
    import gpcr_pkg::*;

    logic signed [DATA_W-1:0] pos_x, pos_y, pos_z;
    logic signed [DATA_W-1:0] vel_x, vel_y, vel_z;
    logic signed [DATA_W-1:0] rest_x, rest_y, rest_z;
    logic signed [DATA_W:0]   dd;
    logic signed [DATA_W-1:0] dd_abs;
    logic [KIND_W-1:0]        kind;

    assign pos_x  = s_tdata[0*DATA_W +: DATA_W];
    assign pos_y  = s_tdata[1*DATA_W +: DATA_W];
    assign pos_z  = s_tdata[2*DATA_W +: DATA_W];
    assign vel_x  = s_tdata[3*DATA_W +: DATA_W];
    assign vel_y  = s_tdata[4*DATA_W +: DATA_W];
    assign vel_z  = s_tdata[5*DATA_W +: DATA_W];
    assign rest_x = s_tdata[6*DATA_W +: DATA_W];
    assign rest_y = s_tdata[7*DATA_W +: DATA_W];
    assign rest_z = s_tdata[8*DATA_W +: DATA_W];

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        priority if (pos_y <= 0)
            kind = KIND_OVR;
        else if (pos_y <= BAND)
            kind = KIND_PEN;
        else
            kind = KIND_NONE;
    end

    // inside the band the distance to the offset is small and positive after abs
    assign dd     = {pos_y[DATA_W-1], pos_y} - {OFFS[DATA_W-1], OFFS};
    assign dd_abs = dd[DATA_W] ? DATA_W'(-dd) : dd[DATA_W-1:0];

    always_comb
    begin
        push_data.kind   = kind;
        push_data.last   = s_tlast;
        push_data.op_a   = (kind == KIND_OVR) ? vel_x : dd_abs;
        push_data.op_b   = vel_y;
        push_data.op_c   = vel_z;
        push_data.disp_x = sat32({pos_x[DATA_W-1], pos_x} - {rest_x[DATA_W-1], rest_x});
        push_data.disp_y = sat32(-{rest_y[DATA_W-1], rest_y});
        push_data.disp_z = sat32({pos_z[DATA_W-1], pos_z} - {rest_z[DATA_W-1], rest_z});
    end

endmodule

FILE: design/gpcr_fifo.sv
module gpcr_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gpcr_pkg::entry_t    push_data,
    input  logic                pop,
    output gpcr_pkg::entry_t    pop_data,
    output gpcr_pkg::q_stat_t   q_stat
);
    import gpcr_pkg::*;

    entry_t          slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg, count_next;

    assign pop_data     = slot_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == (Q_AW+1)'(Q_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: design/gpcr_back.sv
module gpcr_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gpcr_pkg::coef_t             coefs,
    input  gpcr_pkg::q_stat_t           q_stat,
    input  gpcr_pkg::entry_t            q_data,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [gpcr_pkg::OUT_W-1:0]  m_tdata,
    output logic [gpcr_pkg::KIND_W-1:0] m_tuser,
    output logic                        m_tlast
);
    import gpcr_pkg::*;

    logic adv1, adv2, adv3, adv_o;
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;

    // stage 1: products
    logic [KIND_W-1:0]        kind1_reg, kind2_reg, kind3_reg;
    logic                     last1_reg, last2_reg, last3_reg;
    logic signed [PROD_W-1:0] pa1_reg, pb1_reg, pc1_reg;
    logic signed [PROD_W-1:0] pa_next, pb_next, pc_next;
    logic [COEF_W-1:0]        coef_a, coef_b;
    logic [3*DATA_W-1:0]      disp1_reg, disp2_reg, disp3_reg;
    // stage 2: combine
    logic signed [SUM_W-1:0]  sa2_reg, sb2_reg, sc2_reg;
    // stage 3: sign and magnitude
    logic                     na3_reg, nb3_reg, nc3_reg;
    logic [SUM_W-1:0]         ma3_reg, mb3_reg, mc3_reg;
    // output word
    logic [OUT_W-1:0]         tdata_reg, tdata_next;
    logic [KIND_W-1:0]        tuser_reg;
    logic                     tlast_reg;

    assign adv_o = !out_valid_reg || m_tready;
    assign adv3  = !v3_reg || adv_o;
    assign adv2  = !v2_reg || adv3;
    assign adv1  = !v1_reg || adv2;
    assign pop   = !q_stat.empty && adv1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

    // override uses friction and restitution, penalty uses spring and damping
    assign coef_a = (q_data.kind == KIND_OVR) ? coefs.friction    : coefs.spring;
    assign coef_b = (q_data.kind == KIND_OVR) ? coefs.restitution : coefs.damp;

    always_comb
    begin
        pa_next = $signed({1'b0, coef_a}) * q_data.op_a;
        pb_next = $signed({1'b0, coef_b}) * q_data.op_b;
        pc_next = $signed({1'b0, coefs.friction}) * q_data.op_c;
    end

    always_comb
    begin
        tdata_next = '0;
        unique case (kind3_reg)
            KIND_PEN:
            begin
                tdata_next[0*DATA_W +: DATA_W] = rescale(na3_reg, ma3_reg);
            end
            KIND_OVR:
            begin
                tdata_next[1*DATA_W +: DATA_W] = rescale(na3_reg, ma3_reg);
                tdata_next[2*DATA_W +: DATA_W] = rescale(nb3_reg, mb3_reg);
                tdata_next[3*DATA_W +: DATA_W] = rescale(nc3_reg, mc3_reg);
                tdata_next[4*DATA_W +: 3*DATA_W] = disp3_reg;
            end
            default:
            begin
                tdata_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= pop;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv_o)
                out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            kind1_reg <= q_data.kind;
            last1_reg <= q_data.last;
            pa1_reg   <= pa_next;
            pb1_reg   <= pb_next;
            pc1_reg   <= pc_next;
            disp1_reg <= {q_data.disp_z, q_data.disp_y, q_data.disp_x};
        end
        if (adv2)
        begin
            kind2_reg <= kind1_reg;
            last2_reg <= last1_reg;
            disp2_reg <= disp1_reg;
            // penalty force takes spring minus damping before rescaling
            if (kind1_reg == KIND_PEN)
                sa2_reg <= SUM_W'(pa1_reg) - SUM_W'(pb1_reg);
            else
                sa2_reg <= SUM_W'(pa1_reg);
            sb2_reg <= -SUM_W'(pb1_reg);
            sc2_reg <= SUM_W'(pc1_reg);
        end
        if (adv3)
        begin
            kind3_reg <= kind2_reg;
            last3_reg <= last2_reg;
            disp3_reg <= disp2_reg;
            na3_reg   <= sa2_reg[SUM_W-1];
            nb3_reg   <= sb2_reg[SUM_W-1];
            nc3_reg   <= sc2_reg[SUM_W-1];
            ma3_reg   <= sa2_reg[SUM_W-1] ? SUM_W'(-sa2_reg) : SUM_W'(sa2_reg);
            mb3_reg   <= sb2_reg[SUM_W-1] ? SUM_W'(-sb2_reg) : SUM_W'(sb2_reg);
            mc3_reg   <= sc2_reg[SUM_W-1] ? SUM_W'(-sc2_reg) : SUM_W'(sc2_reg);
        end
        if (adv_o)
        begin
            tdata_reg <= tdata_next;
            tuser_reg <= kind3_reg;
            tlast_reg <= last3_reg;
        end
    end

endmodule

FILE: design/ground_plane_contact_response_top.sv
// ground plane contact response, one vertex per word
// input stream s_*: one vertex per word (position, velocity, rest position),
//   s_tlast marks the last vertex of a mesh pass
// output stream m_*: one result word per vertex, m_tuser carries the contact
//   kind (none, penalty band, override), m_tlast copies the input marker
// config channel cfg_*: register index and 31-bit value, always ready; write
//   only while no vertex is in flight
// a vertex is classified on entry and parked in a 4-entry queue; the back end
//   runs a 4-stage pipe: three 32x32 multiplies, penalty combine, sign and
//   magnitude, then round and saturate into the output register
// throughput: one vertex per cycle while m_tready does not hold the output
// reset: queue and pipe empty, coefficients return to their defaults
//   (restitution 0, friction 0, spring 1000, damping 50)
// when m_tready stays low the pipe fills, then the queue, then s_tready drops;
//   no word is lost and resumes in order
module ground_plane_contact_response_top (
    input  logic                         clk,
    input  logic                         rst_n,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, rest_x, rest_y, rest_z
    input  logic [gpcr_pkg::IN_W-1:0]    s_tdata,
    input  logic                         s_tlast,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // force_y_add, new_vel_x, new_vel_y, new_vel_z, new_disp_x, new_disp_y, new_disp_z
    output logic [gpcr_pkg::OUT_W-1:0]   m_tdata,
    // contact_kind
    output logic [gpcr_pkg::KIND_W-1:0]  m_tuser,
    output logic                         m_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [gpcr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [gpcr_pkg::COEF_W-1:0]  cfg_data
);
    import gpcr_pkg::*;

    coef_t   coefs_reg;
    q_stat_t q_stat;
    entry_t  push_data, pop_data;
    logic    push, pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg.restitution <= '0;
            coefs_reg.friction    <= '0;
            coefs_reg.spring      <= SPRING_RST;
            coefs_reg.damp        <= DAMP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RESTITUTION: coefs_reg.restitution <= cfg_data;
                REG_FRICTION:    coefs_reg.friction    <= cfg_data;
                REG_SPRING:      coefs_reg.spring      <= cfg_data;
                REG_DAMP:        coefs_reg.damp        <= cfg_data;
            endcase
        end
    end

    gpcr_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    gpcr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    gpcr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .coefs    (coefs_reg),
        .q_stat   (q_stat),
        .q_data   (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !s_tready)
        else $error("input accepted while queue full");

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_force_only_in_band: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_PEN) |-> (m_tdata[DATA_W-1:0] == '0))
        else $error("penalty force outside penalty band");

    a_override_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_OVR) |-> (m_tdata[OUT_W-1:DATA_W] == '0))
        else $error("override fields set without override");

endmodule
